// ===== src/ewt_pkg.sv =====
`default_nettype none

package ewt_pkg;

    // Command codes carried on the input channel.
    localparam logic [1:0] CMD_ARM   = 2'd0;
    localparam logic [1:0] CMD_EVENT = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_PARAM    = 2'd2;

    // Widths of the arithmetic path.
    localparam int PROD_W = 64;
    localparam int TICK_W = 55;
    localparam int PASS_W = 23;
    localparam logic [PASS_W-1:0] PASS_MAX = {PASS_W{1'b1}};

    // Division by 1000 is done one 16-bit digit at a time.
    localparam int DIGIT_W    = 16;
    localparam int DIV_STAGES = PROD_W / DIGIT_W;
    localparam int REM_W      = 10;
    localparam int DIVX_W     = REM_W + DIGIT_W;
    localparam logic [DIVX_W-1:0] MS_PER_S = DIVX_W'(1000);

    // Reciprocal of 1000, exact for every partial dividend below 2^26.
    localparam int DIV_SHIFT = 36;
    localparam int DIV_M_W   = 27;
    localparam logic [DIV_M_W-1:0] DIV_M = 27'd68719477;

    typedef struct packed {
        logic [1:0] cmd;
        logic       wdmode;
        logic       ms_zero;
    } ctl_t;

endpackage

`default_nettype wire

// ===== src/extended_watchdog_timeout.sv =====
`default_nettype none

// Extended-range watchdog timeout sequencer.
// Software-visible commands arrive on the s_axis channel, one per transaction:
// arm converts a millisecond timeout into counter passes and a remainder,
// a timeout event reloads the hardware counter for the next pass, and clear
// forgets any armed timeout. Every command produces exactly one result
// transaction on m_axis carrying a status, the counter load value with its
// write strobe, the final-timeout notify flag and the interrupt clear flag.
// Clock rate and notify enable are set through the cfg write port; the user
// must do so only while the block is idle, which the block does not enforce.
// Writes take effect at the clock edge where cfg_we is high. Throughput is one
// transaction per cycle unless the result channel stalls. An accepted input
// passes an input register, the 32x32 multiply stage, four divide-by-1000
// digit stages and the result register, which updates pass count and remainder.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops until that result is taken.
// Synchronous reset clears the pipeline, the timeout state and the
// configuration (clock rate 100 MHz, notify disabled).

module extended_watchdog_timeout #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port: index 0 clock_hz, index 1 notify_enable.
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    // Input channel.
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [31:0] timeout_ms, [32] watchdog_mode
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] command
    // Result channel.
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [39:0] m_axis_tdata   // [1:0] status, [33:2] load_value,
                                            // [34] load_write, [35] notify,
                                            // [36] irq_clear
);
    import ewt_pkg::*;

    localparam logic CFG_CLOCK_HZ = 1'b0;
    localparam logic CFG_NOTIFY   = 1'b1;

    logic [31:0] clock_hz_reg;
    logic        notify_en_reg;

    logic        in_valid_reg;
    logic [1:0]  in_cmd_reg;
    logic [31:0] in_ms_reg;
    logic        in_wd_reg;

    logic        adv;

    logic              v_d   [0:DIV_STAGES];
    ctl_t              ctl_d [0:DIV_STAGES];
    logic [PROD_W-1:0] num_d [0:DIV_STAGES];
    logic [PROD_W-1:0] quo_d [0:DIV_STAGES];
    logic [REM_W-1:0]  rem_d [0:DIV_STAGES];

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg  <= 32'd100000000;
            notify_en_reg <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CLOCK_HZ: clock_hz_reg  <= cfg_data;
                CFG_NOTIFY:   notify_en_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together whenever the result slot frees up.
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_cmd_reg <= s_axis_tuser;
            in_ms_reg  <= s_axis_tdata[31:0];
            in_wd_reg  <= s_axis_tdata[32];
        end
    end

    ewt_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (in_valid_reg),
        .in_cmd    (in_cmd_reg),
        .in_ms     (in_ms_reg),
        .in_wdmode (in_wd_reg),
        .clock_hz  (clock_hz_reg),
        .out_valid (v_d[0]),
        .out_ctl   (ctl_d[0]),
        .out_prod  (num_d[0])
    );

    // The quotient and remainder start at zero for every product.
    assign quo_d[0] = '0;
    assign rem_d[0] = '0;

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        ewt_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (v_d[i]),
            .in_ctl    (ctl_d[i]),
            .in_num    (num_d[i]),
            .in_quo    (quo_d[i]),
            .in_rem    (rem_d[i]),
            .out_valid (v_d[i+1]),
            .out_ctl   (ctl_d[i+1]),
            .out_num   (num_d[i+1]),
            .out_quo   (quo_d[i+1]),
            .out_rem   (rem_d[i+1])
        );
    end

    // The final numerator and remainder are not needed past the last digit;
    // the quotient is the tick count and always fits in TICK_W bits.
    ewt_seq #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (v_d[DIV_STAGES]),
        .in_ctl        (ctl_d[DIV_STAGES]),
        .in_ticks      (quo_d[DIV_STAGES][TICK_W-1:0]),
        .notify_enable (notify_en_reg),
        .adv           (adv),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== src/ewt_mul.sv =====
`default_nettype none

module ewt_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [1:0]         in_cmd,
    input  wire logic [31:0]        in_ms,
    input  wire logic               in_wdmode,
    input  wire logic [31:0]        clock_hz,
    output      logic               out_valid,
    output      ewt_pkg::ctl_t      out_ctl,
    output      logic [ewt_pkg::PROD_W-1:0] out_prod
);
    import ewt_pkg::*;

    logic          valid_reg;
    ctl_t          ctl_reg;
    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Full 64-bit product of clock rate and milliseconds.
    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg.cmd     <= in_cmd;
            ctl_reg.wdmode  <= in_wdmode;
            ctl_reg.ms_zero <= (in_ms == 32'd0);
            prod_reg        <= PROD_W'(clock_hz) * PROD_W'(in_ms);
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

// ===== src/ewt_div_step.sv =====
`default_nettype none

module ewt_div_step (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire ewt_pkg::ctl_t              in_ctl,
    input  wire logic [ewt_pkg::PROD_W-1:0] in_num,
    input  wire logic [ewt_pkg::PROD_W-1:0] in_quo,
    input  wire logic [ewt_pkg::REM_W-1:0]  in_rem,
    output      logic                       out_valid,
    output      ewt_pkg::ctl_t              out_ctl,
    output      logic [ewt_pkg::PROD_W-1:0] out_num,
    output      logic [ewt_pkg::PROD_W-1:0] out_quo,
    output      logic [ewt_pkg::REM_W-1:0]  out_rem
);
    import ewt_pkg::*;

    logic                          valid_reg;
    ctl_t                          ctl_reg;
    logic [PROD_W-1:0]             num_reg;
    logic [PROD_W-1:0]             quo_reg;
    logic [REM_W-1:0]              rem_reg;

    logic [DIVX_W-1:0]             x;
    logic [DIVX_W+DIV_M_W-1:0]     recip_prod;
    logic [DIGIT_W-1:0]            q_digit;
    logic [DIVX_W-1:0]             r_full;

    // One long-division digit: the partial dividend is the running remainder
    // followed by the next 16 bits of the numerator.
    always_comb begin
        x          = {in_rem, in_num[PROD_W-1 -: DIGIT_W]};
        recip_prod = (DIVX_W+DIV_M_W)'(x) * (DIVX_W+DIV_M_W)'(DIV_M);
        q_digit    = recip_prod[DIV_SHIFT +: DIGIT_W];
        r_full     = x - DIVX_W'(q_digit) * MS_PER_S;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg <= in_ctl;
            num_reg <= {in_num[PROD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            quo_reg <= {in_quo[PROD_W-DIGIT_W-1:0], q_digit};
            rem_reg <= r_full[REM_W-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_num   = num_reg;
    assign out_quo   = quo_reg;
    assign out_rem   = rem_reg;

endmodule

`default_nettype wire

// ===== src/ewt_seq.sv =====
`default_nettype none

module ewt_seq #(
    parameter int COUNTER_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  wire ewt_pkg::ctl_t              in_ctl,
    input  wire logic [ewt_pkg::TICK_W-1:0] in_ticks,
    input  wire logic                       notify_enable,
    output      logic                       adv,
    input  wire logic                       m_axis_tready,
    output      logic                       m_axis_tvalid,
    output      logic [39:0]                m_axis_tdata
);
    import ewt_pkg::*;

    localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNTER_BITS) - 64'd1);

    logic [PASS_W-1:0]       pass_reg, pass_next;
    logic [COUNTER_BITS-1:0] rem_reg, rem_next;
    logic                    m_valid_reg;
    logic [39:0]             m_data_reg;

    logic [TICK_W-1:0]       hi;
    logic [PASS_W-1:0]       sat;
    logic [1:0]              status;
    logic [31:0]             load;
    logic                    ntf;
    logic                    clr;

    assign adv = !m_valid_reg || m_axis_tready;

    always_comb begin
        pass_next = pass_reg;
        rem_next  = rem_reg;
        status    = ST_OK;
        load      = 32'd0;
        ntf       = 1'b0;
        clr       = 1'b0;
        hi        = in_ticks >> COUNTER_BITS;
        sat       = (hi > TICK_W'(PASS_MAX)) ? PASS_MAX : hi[PASS_W-1:0];
        case (in_ctl.cmd)
            CMD_ARM: begin
                if (in_ctl.ms_zero) begin
                    status = ST_PARAM;
                end else if (in_ctl.wdmode && (hi != '0)) begin
                    status = ST_OVERFLOW;
                end else begin
                    pass_next = sat;
                    rem_next  = in_ticks[COUNTER_BITS-1:0];
                    load      = (hi != '0) ? CNT_MAX : 32'(in_ticks[COUNTER_BITS-1:0]);
                end
            end
            CMD_EVENT: begin
                clr = 1'b1;
                if (pass_reg > PASS_W'(1)) begin
                    pass_next = pass_reg - PASS_W'(1);
                    load      = CNT_MAX;
                end else if (pass_reg == PASS_W'(1)) begin
                    pass_next = '0;
                    load      = 32'(rem_reg);
                end else begin
                    ntf = notify_enable;
                end
            end
            CMD_CLEAR: begin
                pass_next = '0;
                rem_next  = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_reg    <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= in_valid;
            if (in_valid) begin
                pass_reg <= pass_next;
                rem_reg  <= rem_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            m_data_reg <= {3'b000, clr, ntf, (load != 32'd0), load, status};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

`default_nettype wire
